>>> design/mjt_pkg.sv
// shared types, constants and helpers of the minimum-jerk trajectory generator
`default_nettype none

package mjt_pkg;

    localparam int JOINTS = 2;

    // iterations of the shared multiply / divide unit per operation
    localparam int UNIT_STEPS = 48;
    localparam logic [5:0] UNIT_LAST = 6'(UNIT_STEPS - 1);

    // 100 * 256, duration numerator scale
    localparam logic [47:0] NUM_SCALE = 48'd25600;
    // 1.0 in Q1.32 and 2^40 for the step division
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [47:0] STEP_NUM = 48'h0100_0000_0000;
    localparam logic [47:0] ONE_TICK = 48'd256;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SPEED = 2'd1;
    localparam logic [1:0] ST_TOO_SHORT = 2'd2;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic start;
        logic div;
    } unit_ctl_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_V_T2,
        S_V_U2,
        S_V_A,
        S_V_B,
        S_V_P,
        S_V_DIV,
        S_TF_DEN,
        S_TF_NUM,
        S_TF_DIV,
        S_SV,
        S_STEP_DIV,
        S_P_A,
        S_P_T2,
        S_P_T3,
        S_P_B,
        S_P_T4,
        S_P_C,
        S_P_T5,
        S_P_D,
        S_P_SUM,
        S_EMIT,
        S_DONE
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
        logic signed [31:0] r;
        if (x > 65'sh0_7FFF_FFFF)
            r = S32_MAX;
        else if (x < -65'sh0_8000_0000)
            r = S32_MIN;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/mjt_unit.sv
// shared shift-add multiplier and restoring divider, one bit per cycle
`default_nettype none

module mjt_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mjt_pkg::unit_ctl_t  ctl,
    input  wire logic [63:0]         opa,
    input  wire logic [47:0]         opb,
    output logic                     done,
    output logic [111:0]             prod
);

    logic [111:0] p_reg, p_next;
    logic [63:0]  a_reg, a_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         div_reg, div_next;
    logic         done_reg, done_next;

    logic [64:0]  x;
    logic [64:0]  y;
    logic [64:0]  s;
    logic         ge;

    // one adder serves both: add multiplicand, or subtract divisor
    always_comb
    begin
        x  = div_reg ? {1'b0, p_reg[110:47]} : {1'b0, p_reg[111:48]};
        y  = div_reg ? ~{1'b0, a_reg} : (p_reg[0] ? {1'b0, a_reg} : 65'd0);
        s  = x + y + {64'd0, div_reg};
        ge = ~s[64];
    end

    always_comb
    begin
        p_next    = p_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            p_next    = {64'd0, opb};
            a_next    = opa;
            div_next  = ctl.div;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (div_reg)
                p_next = {(ge ? s[63:0] : p_reg[110:47]), p_reg[46:0], ge};
            else
                p_next = {s, p_reg[47:1]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == mjt_pkg::UNIT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            div_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        a_reg <= a_next;
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

`default_nettype wire

>>> design/min_jerk_trajectory_generator.sv
// top level: per-joint minimum-jerk quintic trajectory sequencer
//
// input words (valid / stall) carry kind, joint, start_position,
// target_position and speed. kind 0 plans a new move of one joint, kind 1
// advances that joint by one control period. every input word gives exactly
// one output word (valid / stall) with position_delta and status.
// the control period in ms is written over cfg_valid / cfg_ready / cfg_data;
// cfg_ready is always high, and a write should only come while idle.
// all arithmetic runs through one shared 48-step multiply / divide unit: a
// tick takes eight unit operations when the polynomial is evaluated and none
// when the joint is ended or on its first or last tick; a start takes four
// unit operations from rest and up to eleven when the velocity of a running
// move is carried over.
// one word is worked on at a time; in_stall is high while it is in work.
// the finished word sits in an output register, so a new input word is
// taken while the previous result still waits for the receiver.
// if the receiver stalls, the sequencer holds in its last state until the
// output register frees up.
// reset (rst_n, asynchronous) clears all joint state to zero, not ended,
// and sets the control period to 1 ms.
`default_nettype none

module min_jerk_trajectory_generator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [14:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic               joint,
    input  wire logic signed [31:0] start_position,
    input  wire logic signed [31:0] target_position,
    input  wire logic signed [15:0] speed,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      position_delta,
    output logic [1:0]              status
);

    localparam int J = mjt_pkg::JOINTS;

    // control period register
    logic [14:0] period_reg;

    // per-joint state
    logic signed [31:0] origin_reg [J];
    logic signed [31:0] origin_next [J];
    logic signed [31:0] goal_reg [J];
    logic signed [31:0] goal_next [J];
    logic signed [31:0] v0_reg [J];
    logic signed [31:0] v0_next [J];
    logic signed [31:0] last_reg [J];
    logic signed [31:0] last_next [J];
    logic [47:0]        dur_reg [J];
    logic [47:0]        dur_next [J];
    logic [33:0]        step_reg [J];
    logic [33:0]        step_next [J];
    logic [33:0]        tau_reg [J];
    logic [33:0]        tau_next [J];
    logic               done_reg [J];
    logic               done_next [J];

    // the word in work
    mjt_pkg::state_t    state_reg, state_next;
    logic               issued_reg, issued_next;
    logic               kind_reg, kind_next;
    logic               joint_reg, joint_next;
    logic signed [31:0] spos_reg, spos_next;
    logic signed [31:0] tpos_reg, tpos_next;
    logic signed [15:0] spd_reg, spd_next;

    // working registers
    logic signed [32:0] d_reg, d_next;
    logic signed [31:0] v0w_reg, v0w_next;
    logic [31:0]        t_reg, t_next;
    logic [31:0]        tp_reg, tp_next;
    logic [32:0]        u2_reg, u2_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] vel_reg, vel_next;
    logic [29:0]        den_reg, den_next;
    logic [47:0]        tf_reg, tf_next;
    logic signed [31:0] emit_reg, emit_next;
    logic signed [31:0] rdelta_reg, rdelta_next;
    logic [1:0]         rstatus_reg, rstatus_next;

    // output register
    logic               ovalid_reg, ovalid_next;
    logic signed [31:0] delta_reg, delta_next;
    logic [1:0]         status_reg, status_next;

    // shared unit
    mjt_pkg::unit_ctl_t ctl;
    logic               unit_start;
    logic               unit_div;
    logic [63:0]        opa;
    logic [47:0]        opb;
    logic               unit_done;
    logic [111:0]       prod;

    assign ctl = '{start: unit_start, div: unit_div};

    mjt_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .opa   (opa),
        .opb   (opb),
        .done  (unit_done),
        .prod  (prod)
    );

    // current joint's values
    logic signed [31:0] org_c, goal_c, v0_c, last_c;
    logic [47:0]        dur_c;
    logic [33:0]        step_c, tau_c;
    logic               done_c;
    logic [34:0]        tau_sum;
    logic               tau_over;

    // coefficient operand of a scaled product, sign and magnitude
    logic signed [63:0] d64, v64, coef, term_s;
    logic               mq_neg;
    logic [63:0]        mq_mag, term;
    logic [32:0]        tsel;
    logic [32:0]        u;
    logic [14:0]        per;
    logic signed [32:0] span;
    logic [32:0]        span_mag;
    logic [31:0]        vel_mag;
    logic signed [64:0] qs;
    logic [30:0]        r31;
    logic signed [31:0] sv_val;
    logic               sv_fin;
    logic [33:0]        st_q;

    assign org_c    = origin_reg[joint_reg];
    assign goal_c   = goal_reg[joint_reg];
    assign v0_c     = v0_reg[joint_reg];
    assign last_c   = last_reg[joint_reg];
    assign dur_c    = dur_reg[joint_reg];
    assign step_c   = step_reg[joint_reg];
    assign tau_c    = tau_reg[joint_reg];
    assign done_c   = done_reg[joint_reg];
    assign tau_sum  = {1'b0, tau_c} + {1'b0, step_c};
    assign tau_over = |tau_sum[34:32];

    assign d64      = {{31{d_reg[32]}}, d_reg};
    assign v64      = {{32{v0w_reg[31]}}, v0w_reg};
    assign u        = mjt_pkg::ONE_Q32 - {1'b0, t_reg};
    assign per      = (period_reg == 15'd0) ? 15'd1 : period_reg;
    assign span     = {tpos_reg[31], tpos_reg} - {spos_reg[31], spos_reg};
    assign span_mag = span[32] ? 33'(-span) : span;
    assign vel_mag  = vel_reg[31] ? 32'(-vel_reg) : vel_reg;
    assign r31      = prod[38:8];
    assign st_q     = prod[33:0];

    // coefficient and time power of the scaled product in this state
    always_comb
    begin
        case (state_reg)
            mjt_pkg::S_V_A: coef = v64 <<< 1;
            mjt_pkg::S_V_B: coef = 64'sd30 * d64 - 64'sd15 * v64;
            mjt_pkg::S_V_P: coef = acc_reg;
            mjt_pkg::S_P_A: coef = v64;
            mjt_pkg::S_P_B: coef = 64'sd10 * d64 - 64'sd6 * v64;
            mjt_pkg::S_P_C: coef = 64'sd8 * v64 - 64'sd15 * d64;
            mjt_pkg::S_P_D: coef = 64'sd6 * d64 - 64'sd3 * v64;
            default:        coef = 64'sd0;
        endcase
        case (state_reg)
            mjt_pkg::S_V_A, mjt_pkg::S_P_A: tsel = {1'b0, t_reg};
            mjt_pkg::S_V_P:                  tsel = u2_reg;
            default:                         tsel = {1'b0, tp_reg};
        endcase
        mq_neg = coef[63];
        mq_mag = mq_neg ? 64'(-coef) : coef;
        term   = prod[95:32];
        term_s = mq_neg ? -$signed(term) : $signed(term);
    end

    // operands of the shared unit
    always_comb
    begin
        unit_div = 1'b0;
        case (state_reg)
            mjt_pkg::S_V_T2, mjt_pkg::S_P_T2:
            begin
                opa = {32'd0, t_reg};
                opb = {16'd0, t_reg};
            end
            mjt_pkg::S_P_T3, mjt_pkg::S_P_T4, mjt_pkg::S_P_T5:
            begin
                opa = {32'd0, tp_reg};
                opb = {16'd0, t_reg};
            end
            mjt_pkg::S_V_U2:
            begin
                opa = {31'd0, u};
                opb = {15'd0, u};
            end
            mjt_pkg::S_V_DIV:
            begin
                unit_div = 1'b1;
                opa = {16'd0, dur_c};
                opb = {tf_reg[39:0], 8'd0};
            end
            mjt_pkg::S_TF_DEN:
            begin
                opa = {49'd0, per};
                opb = {33'd0, spd_reg[14:0]};
            end
            mjt_pkg::S_TF_NUM:
            begin
                opa = {31'd0, span_mag};
                opb = mjt_pkg::NUM_SCALE;
            end
            mjt_pkg::S_TF_DIV:
            begin
                unit_div = 1'b1;
                opa = {34'd0, den_reg};
                opb = tf_reg;
            end
            mjt_pkg::S_SV:
            begin
                opa = {32'd0, vel_mag};
                opb = tf_reg;
            end
            mjt_pkg::S_STEP_DIV:
            begin
                unit_div = 1'b1;
                opa = {16'd0, tf_reg};
                opb = mjt_pkg::STEP_NUM;
            end
            default:
            begin
                opa = mq_mag;
                opb = {15'd0, tsel};
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        issued_next  = issued_reg;
        kind_next    = kind_reg;
        joint_next   = joint_reg;
        spos_next    = spos_reg;
        tpos_next    = tpos_reg;
        spd_next     = spd_reg;
        d_next       = d_reg;
        v0w_next     = v0w_reg;
        t_next       = t_reg;
        tp_next      = tp_reg;
        u2_next      = u2_reg;
        acc_next     = acc_reg;
        vel_next     = vel_reg;
        den_next     = den_reg;
        tf_next      = tf_reg;
        emit_next    = emit_reg;
        rdelta_next  = rdelta_reg;
        rstatus_next = rstatus_reg;
        delta_next   = delta_reg;
        status_next  = status_reg;
        ovalid_next  = ovalid_reg && out_stall;
        unit_start   = 1'b0;
        qs           = 65'sd0;
        sv_val       = 32'sd0;
        sv_fin       = 1'b0;
        for (int i = 0; i < J; i++)
        begin
            origin_next[i] = origin_reg[i];
            goal_next[i]   = goal_reg[i];
            v0_next[i]     = v0_reg[i];
            last_next[i]   = last_reg[i];
            dur_next[i]    = dur_reg[i];
            step_next[i]   = step_reg[i];
            tau_next[i]    = tau_reg[i];
            done_next[i]   = done_reg[i];
        end

        case (state_reg)
            mjt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    joint_next = joint;
                    spos_next  = start_position;
                    tpos_next  = target_position;
                    spd_next   = speed;
                    state_next = mjt_pkg::S_DISPATCH;
                end
            end

            mjt_pkg::S_DISPATCH:
            begin
                rdelta_next  = 32'sd0;
                rstatus_next = mjt_pkg::ST_OK;
                d_next       = {goal_c[31], goal_c} - {org_c[31], org_c};
                v0w_next     = v0_c;
                t_next       = tau_c[31:0];
                acc_next     = 64'sd0;
                vel_next     = 32'sd0;
                issued_next  = 1'b0;
                if (int'(joint_reg) >= J)
                    state_next = mjt_pkg::S_DONE;
                else if (!kind_reg)
                begin
                    if (spd_reg[15] || spd_reg == 16'sd0)
                    begin
                        rstatus_next = mjt_pkg::ST_BAD_SPEED;
                        state_next   = mjt_pkg::S_DONE;
                    end
                    else if (done_c || tau_c == 34'd0 || tau_over)
                        state_next = mjt_pkg::S_TF_DEN;
                    else
                    begin
                        // inner term starts at v0
                        acc_next   = {{32{v0_c[31]}}, v0_c};
                        state_next = mjt_pkg::S_V_T2;
                    end
                end
                else if (done_c)
                begin
                    emit_next  = goal_c;
                    state_next = mjt_pkg::S_EMIT;
                end
                else if (tau_c == 34'd0)
                begin
                    tau_next[joint_reg] = tau_sum[33:0];
                    emit_next  = org_c;
                    state_next = mjt_pkg::S_EMIT;
                end
                else if (!tau_over)
                begin
                    tau_next[joint_reg] = tau_sum[33:0];
                    state_next = mjt_pkg::S_P_A;
                end
                else
                begin
                    // end of the move: no setpoint change this tick
                    done_next[joint_reg] = 1'b1;
                    state_next = mjt_pkg::S_DONE;
                end
            end

            // powers of tau, tau squared shared by velocity and polynomial
            mjt_pkg::S_V_T2, mjt_pkg::S_P_T2, mjt_pkg::S_P_T3, mjt_pkg::S_P_T4,
            mjt_pkg::S_P_T5:
            begin
                if (!issued_reg)
                begin
                    unit_start  = 1'b1;
                    issued_next = 1'b1;
                end
                else if (unit_done)
                begin
                    issued_next = 1'b0;
                    tp_next     = prod[63:32];
                    case (state_reg)
                        mjt_pkg::S_V_T2: state_next = mjt_pkg::S_V_U2;
                        mjt_pkg::S_P_T2: state_next = mjt_pkg::S_P_T3;
                        mjt_pkg::S_P_T3: state_next = mjt_pkg::S_P_B;
                        mjt_pkg::S_P_T4: state_next = mjt_pkg::S_P_C;
                        default:         state_next = mjt_pkg::S_P_D;
                    endcase
                end
            end

            mjt_pkg::S_V_U2:
            begin
                if (!issued_reg)
                begin
                    unit_start  = 1'b1;
                    issued_next = 1'b1;
                end
                else if (unit_done)
                begin
                    issued_next = 1'b0;
                    u2_next     = prod[64:32];
                    state_next  = mjt_pkg::S_V_A;
                end
            end

            // scaled products accumulated into the running sum
            mjt_pkg::S_V_A, mjt_pkg::S_V_B, mjt_pkg::S_P_A, mjt_pkg::S_P_B,
            mjt_pkg::S_P_C, mjt_pkg::S_P_D:
            begin
                if (!issued_reg)
                begin
                    unit_start  = 1'b1;
                    issued_next = 1'b1;
                end
                else if (unit_done)
                begin
                    issued_next = 1'b0;
                    acc_next    = acc_reg + term_s;
                    case (state_reg)
                        mjt_pkg::S_V_A: state_next = mjt_pkg::S_V_B;
                        mjt_pkg::S_V_B: state_next = mjt_pkg::S_V_P;
                        mjt_pkg::S_P_A: state_next = mjt_pkg::S_P_T2;
                        mjt_pkg::S_P_B: state_next = mjt_pkg::S_P_T4;
                        mjt_pkg::S_P_C: state_next = mjt_pkg::S_P_T5;
                        default:        state_next = mjt_pkg::S_P_SUM;
                    endcase
                end
            end

            // inner times (1 - tau)^2, magnitude kept, sign stays in acc
            mjt_pkg::S_V_P:
            begin
                if (!issued_reg)
                begin
                    unit_start  = 1'b1;
                    issued_next = 1'b1;
                end
                else if (unit_done)
                begin
                    issued_next = 1'b0;
                    tf_next     = prod[79:32];
                    state_next  = mjt_pkg::S_V_DIV;
                end
            end

            mjt_pkg::S_V_DIV:
            begin
                if (!issued_reg)
                begin
                    if (dur_c == 48'd0)
                    begin
                        vel_next   = 32'sd0;
                        state_next = mjt_pkg::S_TF_DEN;
                    end
                    else
                    begin
                        unit_start  = 1'b1;
                        issued_next = 1'b1;
                    end
                end
                else if (unit_done)
                begin
                    issued_next = 1'b0;
                    qs = acc_reg[63] ? -$signed({17'd0, prod[47:0]})
                                     : $signed({17'd0, prod[47:0]});
                    vel_next   = mjt_pkg::sat32(qs);
                    state_next = mjt_pkg::S_TF_DEN;
                end
            end

            mjt_pkg::S_TF_DEN:
            begin
                if (!issued_reg)
                begin
                    unit_start  = 1'b1;
                    issued_next = 1'b1;
                end
                else if (unit_done)
                begin
                    issued_next = 1'b0;
                    den_next    = prod[29:0];
                    state_next  = mjt_pkg::S_TF_NUM;
                end
            end

            mjt_pkg::S_TF_NUM:
            begin
                if (!issued_reg)
                begin
                    unit_start  = 1'b1;
                    issued_next = 1'b1;
                end
                else if (unit_done)
                begin
                    issued_next = 1'b0;
                    tf_next     = prod[47:0];
                    state_next  = mjt_pkg::S_TF_DIV;
                end
            end

            mjt_pkg::S_TF_DIV:
            begin
                if (!issued_reg)
                begin
                    unit_start  = 1'b1;
                    issued_next = 1'b1;
                end
                else if (unit_done)
                begin
                    issued_next = 1'b0;
                    tf_next     = prod[47:0];
                    state_next  = mjt_pkg::S_SV;
                end
            end

            // carried velocity rescaled to the new duration, then plan stored
            mjt_pkg::S_SV:
            begin
                if (!issued_reg)
                begin
                    if (vel_reg == 32'sd0)
                    begin
                        sv_val = 32'sd0;
                        sv_fin = 1'b1;
                    end
                    else
                    begin
                        unit_start  = 1'b1;
                        issued_next = 1'b1;
                    end
                end
                else if (unit_done)
                begin
                    issued_next = 1'b0;
                    sv_fin      = 1'b1;
                    if (|prod[111:39])
                        sv_val = vel_reg[31] ? mjt_pkg::S32_MIN : mjt_pkg::S32_MAX;
                    else
                        sv_val = vel_reg[31] ? -$signed({1'b0, r31}) : $signed({1'b0, r31});
                end
                if (sv_fin)
                begin
                    origin_next[joint_reg] = spos_reg;
                    last_next[joint_reg]   = spos_reg;
                    goal_next[joint_reg]   = tpos_reg;
                    dur_next[joint_reg]    = tf_reg;
                    v0_next[joint_reg]     = sv_val;
                    if (tf_reg < mjt_pkg::ONE_TICK)
                    begin
                        done_next[joint_reg] = 1'b1;
                        rstatus_next = mjt_pkg::ST_TOO_SHORT;
                        state_next   = mjt_pkg::S_DONE;
                    end
                    else
                        state_next = mjt_pkg::S_STEP_DIV;
                end
            end

            mjt_pkg::S_STEP_DIV:
            begin
                if (!issued_reg)
                begin
                    unit_start  = 1'b1;
                    issued_next = 1'b1;
                end
                else if (unit_done)
                begin
                    issued_next = 1'b0;
                    step_next[joint_reg] = (st_q == 34'd0) ? 34'd1 : st_q;
                    tau_next[joint_reg]  = 34'd0;
                    done_next[joint_reg] = 1'b0;
                    state_next = mjt_pkg::S_DONE;
                end
            end

            mjt_pkg::S_P_SUM:
            begin
                emit_next  = mjt_pkg::sat32({{33{org_c[31]}}, org_c} + {acc_reg[63], acc_reg});
                state_next = mjt_pkg::S_EMIT;
            end

            mjt_pkg::S_EMIT:
            begin
                rdelta_next = mjt_pkg::sat32({{33{emit_reg[31]}}, emit_reg}
                                            - {{33{last_c[31]}}, last_c});
                last_next[joint_reg] = emit_reg;
                state_next = mjt_pkg::S_DONE;
            end

            mjt_pkg::S_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    delta_next  = rdelta_reg;
                    status_next = rstatus_reg;
                    state_next  = mjt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mjt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mjt_pkg::S_IDLE;
            issued_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            period_reg <= 15'd1;
            for (int i = 0; i < J; i++)
            begin
                origin_reg[i] <= 32'sd0;
                goal_reg[i]   <= 32'sd0;
                v0_reg[i]     <= 32'sd0;
                last_reg[i]   <= 32'sd0;
                dur_reg[i]    <= 48'd0;
                step_reg[i]   <= 34'd0;
                tau_reg[i]    <= 34'd0;
                done_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid)
                period_reg <= cfg_data;
            for (int i = 0; i < J; i++)
            begin
                origin_reg[i] <= origin_next[i];
                goal_reg[i]   <= goal_next[i];
                v0_reg[i]     <= v0_next[i];
                last_reg[i]   <= last_next[i];
                dur_reg[i]    <= dur_next[i];
                step_reg[i]   <= step_next[i];
                tau_reg[i]    <= tau_next[i];
                done_reg[i]   <= done_next[i];
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        joint_reg   <= joint_next;
        spos_reg    <= spos_next;
        tpos_reg    <= tpos_next;
        spd_reg     <= spd_next;
        d_reg       <= d_next;
        v0w_reg     <= v0w_next;
        t_reg       <= t_next;
        tp_reg      <= tp_next;
        u2_reg      <= u2_next;
        acc_reg     <= acc_next;
        vel_reg     <= vel_next;
        den_reg     <= den_next;
        tf_reg      <= tf_next;
        emit_reg    <= emit_next;
        rdelta_reg  <= rdelta_next;
        rstatus_reg <= rstatus_next;
        delta_reg   <= delta_next;
        status_reg  <= status_next;
    end

    // a new word is taken whenever the sequencer is idle
    assign in_stall       = (state_reg != mjt_pkg::S_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = ovalid_reg;
    assign position_delta = delta_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire
